### design/lcdwpw_pkg.sv
package lcdwpw_pkg;

    localparam int PANEL_SIZE       = 240;
    localparam int BYTE_COUNT_LIMIT = 31;
    localparam int COUNT_W          = $clog2(BYTE_COUNT_LIMIT + 1);
    localparam int SAVED_DEPTH      = 4;
    localparam int SAVED_IDX_W      = $clog2(SAVED_DEPTH);
    localparam int WINDOW_BYTES     = 4;
    localparam int PIXEL_BYTES      = 2;
    localparam int CURSOR_W         = 9;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;

    localparam logic [7:0] CMD_COLUMNS = 8'h2A;
    localparam logic [7:0] CMD_ROWS    = 8'h2B;
    localparam logic [7:0] CMD_PIXELS  = 8'h2C;

    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_COLUMN = 2'd1;
    localparam logic [1:0] MODE_ROW    = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_WIN_X = 2'd1;
    localparam logic [1:0] OP_WIN_Y = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] a;
        logic [7:0] b;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] value;
    } t_pixel;

    typedef logic [255:0][7:0] t_row_min_tab;

    function automatic t_row_min_tab f_build_row_min();
        t_row_min_tab tab;
        int r;
        int d;
        int n;
        int s;
        r = PANEL_SIZE / 2;
        for (int y = 0; y < 256; y++) begin
            d = (y >= r) ? (y - r) : (r - y);
            n = (d <= r) ? (r * r - d * d) : 0;
            s = 0;
            for (int k = 0; k <= 256; k++) begin
                if (s * s < n) begin
                    s = s + 1;
                end
            end
            tab[y] = (s <= r) ? 8'(r - s) : 8'd0;
        end
        return tab;
    endfunction

    localparam t_row_min_tab ROW_MIN = f_build_row_min();

    function automatic logic [CURSOR_W-1:0] f_sat_inc(input logic [CURSOR_W-1:0] v);
        return (v != CURSOR_MAX) ? v + 1'b1 : v;
    endfunction

    function automatic logic f_in_mask(input logic [CURSOR_W-1:0] x,
                                       input logic [CURSOR_W-1:0] y);
        logic [7:0] lo;
        lo = ROW_MIN[y[7:0]];
        return ({1'b0, y} < 10'(PANEL_SIZE)) &&
               (x >= {1'b0, lo}) &&
               (({1'b0, x} + {2'b00, lo}) < 10'(PANEL_SIZE));
    endfunction

endpackage

### design/lcdwpw_front.sv
module lcdwpw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_is_data,
    input  logic [7:0]        i_byte_value,
    output logic              o_cmd_valid,
    output lcdwpw_pkg::t_cmd  o_cmd
);

    logic [1:0]                      r_mode;
    logic [1:0]                      n_mode;
    logic [lcdwpw_pkg::COUNT_W-1:0]  r_count;
    logic [lcdwpw_pkg::COUNT_W-1:0]  n_count;
    logic [lcdwpw_pkg::COUNT_W-1:0]  cnt_inc;
    logic [7:0]                      r_saved [lcdwpw_pkg::SAVED_DEPTH];
    logic [7:0]                      n_saved [lcdwpw_pkg::SAVED_DEPTH];

    assign cnt_inc = (r_count < lcdwpw_pkg::COUNT_W'(lcdwpw_pkg::BYTE_COUNT_LIMIT)) ?
                     r_count + 1'b1 : r_count;

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_saved     = r_saved;
        o_cmd_valid = 1'b0;
        o_cmd.op    = lcdwpw_pkg::OP_PIXEL;
        o_cmd.a     = '0;
        o_cmd.b     = '0;
        if (i_accept) begin
            if (!i_is_data) begin
                unique case (i_byte_value)
                    lcdwpw_pkg::CMD_COLUMNS: n_mode = lcdwpw_pkg::MODE_COLUMN;
                    lcdwpw_pkg::CMD_ROWS:    n_mode = lcdwpw_pkg::MODE_ROW;
                    lcdwpw_pkg::CMD_PIXELS:  n_mode = lcdwpw_pkg::MODE_PIXEL;
                    default:                 n_mode = lcdwpw_pkg::MODE_IGNORE;
                endcase
                n_count = '0;
            end else begin
                if (r_count < lcdwpw_pkg::COUNT_W'(lcdwpw_pkg::SAVED_DEPTH)) begin
                    n_saved[r_count[lcdwpw_pkg::SAVED_IDX_W-1:0]] = i_byte_value;
                end
                n_count = cnt_inc;
                unique case (r_mode)
                    lcdwpw_pkg::MODE_COLUMN, lcdwpw_pkg::MODE_ROW: begin
                        if (cnt_inc == lcdwpw_pkg::COUNT_W'(lcdwpw_pkg::WINDOW_BYTES)) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.op    = (r_mode == lcdwpw_pkg::MODE_COLUMN) ?
                                          lcdwpw_pkg::OP_WIN_X : lcdwpw_pkg::OP_WIN_Y;
                            o_cmd.a     = n_saved[1];
                            o_cmd.b     = n_saved[3];
                        end
                    end
                    lcdwpw_pkg::MODE_PIXEL: begin
                        if (cnt_inc == lcdwpw_pkg::COUNT_W'(lcdwpw_pkg::PIXEL_BYTES)) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.op    = lcdwpw_pkg::OP_PIXEL;
                            o_cmd.a     = n_saved[0];
                            o_cmd.b     = n_saved[1];
                            n_count     = '0;
                        end
                    end
                    lcdwpw_pkg::MODE_IGNORE: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lcdwpw_pkg::MODE_PIXEL;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_saved <= n_saved;
    end

endmodule

### design/lcdwpw_cmd_queue.sv
module lcdwpw_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcdwpw_pkg::t_cmd  i_cmd,
    output logic              o_full,
    output logic              o_empty,
    input  logic              i_pop,
    output lcdwpw_pkg::t_cmd  o_cmd
);

    lcdwpw_pkg::t_cmd                    r_mem [lcdwpw_pkg::QUEUE_DEPTH];
    logic [lcdwpw_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [lcdwpw_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [lcdwpw_pkg::QUEUE_CNT_W-1:0]  r_cnt;
    logic                                do_push;
    logic                                do_pop;

    assign o_full  = (r_cnt == lcdwpw_pkg::QUEUE_CNT_W'(lcdwpw_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == lcdwpw_pkg::QUEUE_PTR_W'(lcdwpw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == lcdwpw_pkg::QUEUE_PTR_W'(lcdwpw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### design/lcdwpw_back.sv
module lcdwpw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  lcdwpw_pkg::t_cmd    i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output lcdwpw_pkg::t_pixel  o_pixel
);

    logic [7:0]                          r_start_x;
    logic [7:0]                          r_end_x;
    logic [7:0]                          r_start_y;
    logic [7:0]                          r_end_y;
    logic [lcdwpw_pkg::CURSOR_W-1:0]     r_cur_x;
    logic [lcdwpw_pkg::CURSOR_W-1:0]     r_cur_y;
    logic [7:0]                          n_start_x;
    logic [7:0]                          n_end_x;
    logic [7:0]                          n_start_y;
    logic [7:0]                          n_end_y;
    logic [lcdwpw_pkg::CURSOR_W-1:0]     n_cur_x;
    logic [lcdwpw_pkg::CURSOR_W-1:0]     n_cur_y;
    logic [lcdwpw_pkg::CURSOR_W-1:0]     step_x;
    logic [lcdwpw_pkg::CURSOR_W-1:0]     step_y;

    lcdwpw_pkg::t_pixel                  r_q [lcdwpw_pkg::QUEUE_DEPTH];
    logic [lcdwpw_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [lcdwpw_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [lcdwpw_pkg::QUEUE_CNT_W-1:0]  r_cnt;
    logic                                out_space;
    logic                                out_push;
    logic                                out_pop;
    lcdwpw_pkg::t_pixel                  push_pixel;

    assign o_empty   = (r_cnt == '0);
    assign o_pixel   = r_q[r_rd_ptr];
    assign out_pop   = i_pop && !o_empty;
    assign out_space = (r_cnt != lcdwpw_pkg::QUEUE_CNT_W'(lcdwpw_pkg::QUEUE_DEPTH)) || out_pop;
    assign o_cmd_pop = !i_cmd_empty && ((i_cmd.op != lcdwpw_pkg::OP_PIXEL) || out_space);
    assign step_x    = lcdwpw_pkg::f_sat_inc(r_cur_x);
    assign step_y    = lcdwpw_pkg::f_sat_inc(r_cur_y);

    assign push_pixel.x     = r_cur_x[7:0];
    assign push_pixel.y     = r_cur_y[7:0];
    assign push_pixel.value = {i_cmd.b, i_cmd.a};

    always_comb begin
        n_start_x = r_start_x;
        n_end_x   = r_end_x;
        n_start_y = r_start_y;
        n_end_y   = r_end_y;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        out_push  = 1'b0;
        if (o_cmd_pop) begin
            unique case (i_cmd.op)
                lcdwpw_pkg::OP_WIN_X: begin
                    n_start_x = i_cmd.a;
                    n_end_x   = i_cmd.b;
                    n_cur_x   = {1'b0, i_cmd.a};
                end
                lcdwpw_pkg::OP_WIN_Y: begin
                    n_start_y = i_cmd.a;
                    n_end_y   = i_cmd.b;
                    n_cur_y   = {1'b0, i_cmd.a};
                end
                lcdwpw_pkg::OP_PIXEL: begin
                    out_push = lcdwpw_pkg::f_in_mask(r_cur_x, r_cur_y);
                    if (step_x == {1'b0, r_end_x}) begin
                        n_cur_x = {1'b0, r_start_x};
                        n_cur_y = (step_y == {1'b0, r_end_y}) ? {1'b0, r_start_y} : step_y;
                    end else begin
                        n_cur_x = step_x;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_end_x   <= '0;
            r_start_y <= '0;
            r_end_y   <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_cnt     <= '0;
        end else begin
            r_start_x <= n_start_x;
            r_end_x   <= n_end_x;
            r_start_y <= n_start_y;
            r_end_y   <= n_end_y;
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            if (out_push) begin
                r_wr_ptr <= (r_wr_ptr == lcdwpw_pkg::QUEUE_PTR_W'(lcdwpw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (out_pop) begin
                r_rd_ptr <= (r_rd_ptr == lcdwpw_pkg::QUEUE_PTR_W'(lcdwpw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (out_push && !out_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (out_pop && !out_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_q[r_wr_ptr] <= push_pixel;
        end
    end

endmodule

### design/lcd_window_pixel_writer_core.sv
// Window pixel writer for a round panel.
// Input: one display byte per word, i_is_data low for a command byte and
// high for a data byte; a word is taken on a clock edge with push high and
// full low. Commands 0x2A and 0x2B open a column or row window load (four
// data bytes, start in byte 1, end in byte 3); 0x2C opens pixel writes,
// two data bytes per pixel, first byte low.
// Output: one word per pixel that falls inside the round panel mask, shown
// while empty is low and taken on an edge with pop high.
// A pixel command waits in the command queue, then its pixel goes to the result queue.
// Throughput: one input word per cycle while full is low, set by the
// combinational decode in the front end and the one-command-per-cycle cursor
// unit in the back end, joined by a two-entry command queue.
// When pop stays low the two-entry result queue fills, the back end holds
// pixel commands, the command queue fills and full rises to hold the source.
// Reset (synchronous, i_rst_n low) returns to pixel mode with zero windows
// and cursors and empties both queues; no clearing pass is needed.
module lcd_window_pixel_writer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  logic         i_is_data,
    input  logic [7:0]   i_byte_value,
    output logic         empty,
    input  logic         pop,
    output logic [7:0]   o_pixel_x,
    output logic [7:0]   o_pixel_y,
    output logic [15:0]  o_pixel_value
);

    logic                accept;
    logic                cmd_push;
    lcdwpw_pkg::t_cmd    cmd_in;
    logic                cmd_full;
    logic                cmd_empty;
    logic                cmd_pop;
    lcdwpw_pkg::t_cmd    cmd_out;
    lcdwpw_pkg::t_pixel  pixel;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    lcdwpw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_is_data    (i_is_data),
        .i_byte_value (i_byte_value),
        .o_cmd_valid  (cmd_push),
        .o_cmd        (cmd_in)
    );

    lcdwpw_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out)
    );

    lcdwpw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_pixel     (pixel)
    );

    assign o_pixel_x     = pixel.x;
    assign o_pixel_y     = pixel.y;
    assign o_pixel_value = pixel.value;

`ifndef SYNTHESIS
    a_no_cmd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queue written while full");

    a_result_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> lcdwpw_pkg::f_in_mask({1'b0, o_pixel_x}, {1'b0, o_pixel_y}))
        else $error("result outside panel mask");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("back end took a command from an empty queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");
`endif

endmodule

### dv/lcd_window_pixel_writer_core_tb.sv
`timescale 1ns / 100ps

module lcd_window_pixel_writer_core_tb;
    import lcdwpw_pkg::*;

    localparam int ITEMS      = 1900;
    localparam int TAIL_ITEMS = 200;
    localparam int DRAIN      = 20;
    localparam int STALL_LEN  = 400;
    localparam int WD_LIMIT   = 4000;

    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_PIX
    } chk_e;

    typedef struct packed {
        logic       is_data;
        logic [7:0] data;
        chk_e       chk;
        t_pixel     pix;
    } byte_row_t;

    localparam byte_row_t DIR_TAB [24] = '{
        '{1'b1, 8'h34, CHK_NONE, '0},
        '{1'b1, 8'h12, CHK_NONE, '0},
        '{1'b0, CMD_COLUMNS, CHK_PRED, '0},
        '{1'b1, 8'h00, CHK_PRED, '0},
        '{1'b1, 8'h00, CHK_PRED, '0},
        '{1'b1, 8'h00, CHK_PRED, '0},
        '{1'b1, 8'hEF, CHK_PRED, '0},
        '{1'b0, CMD_ROWS, CHK_PRED, '0},
        '{1'b1, 8'h00, CHK_PRED, '0},
        '{1'b1, 8'h78, CHK_PRED, '0},
        '{1'b1, 8'h00, CHK_PRED, '0},
        '{1'b1, 8'hEF, CHK_PRED, '0},
        '{1'b1, 8'h55, CHK_NONE, '0},
        '{1'b0, CMD_PIXELS, CHK_NONE, '0},
        '{1'b1, 8'hFF, CHK_NONE, '0},
        '{1'b1, 8'hFF, CHK_PIX, '{8'd0, 8'd120, 16'hFFFF}},
        '{1'b1, 8'h00, CHK_NONE, '0},
        '{1'b1, 8'h00, CHK_PIX, '{8'd1, 8'd120, 16'h0000}},
        '{1'b0, 8'h00, CHK_NONE, '0},
        '{1'b1, 8'h11, CHK_NONE, '0},
        '{1'b1, 8'h22, CHK_NONE, '0},
        '{1'b0, CMD_PIXELS, CHK_NONE, '0},
        '{1'b1, 8'h5A, CHK_NONE, '0},
        '{1'b1, 8'hA5, CHK_PIX, '{8'd2, 8'd120, 16'hA55A}}
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic        i_is_data    = 1'b0;
    logic [7:0]  i_byte_value = 8'h00;
    logic        empty;
    logic        pop          = 1'b0;
    logic [7:0]  o_pixel_x;
    logic [7:0]  o_pixel_y;
    logic [15:0] o_pixel_value;

    byte_row_t   byte_q[$];
    t_pixel      pixel_q[$];
    int          row_lo[256];
    int          useful;
    int          errors       = 0;
    int          results_seen = 0;
    int          idle_cycles  = 0;
    int          hold_left    = 0;
    bit          stall_done   = 1'b0;
    bit          quiet        = 1'b0;

    logic [1:0]          wr_mode;
    int                  wr_count;
    logic [7:0]          wr_saved[SAVED_DEPTH];
    logic [7:0]          wr_start_x, wr_end_x, wr_start_y, wr_end_y;
    logic [CURSOR_W-1:0] wr_cur_x, wr_cur_y;

    lcd_window_pixel_writer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_is_data     (i_is_data),
        .i_byte_value  (i_byte_value),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_value (o_pixel_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CURSOR_W-1:0] cursor_step(input logic [CURSOR_W-1:0] c);
        return (c == CURSOR_MAX) ? c : c + 1'b1;
    endfunction

    task automatic predict_pixel(input logic d, input logic [7:0] b,
                                 output logic hit, output t_pixel px);
        int lo;
        hit = 1'b0;
        px  = '0;
        if (!d) begin
            case (b)
                CMD_COLUMNS: wr_mode = MODE_COLUMN;
                CMD_ROWS:    wr_mode = MODE_ROW;
                CMD_PIXELS:  wr_mode = MODE_PIXEL;
                default:     wr_mode = MODE_IGNORE;
            endcase
            wr_count = 0;
        end else begin
            if (wr_count < SAVED_DEPTH) begin
                wr_saved[wr_count] = b;
            end
            if (wr_count < BYTE_COUNT_LIMIT) begin
                wr_count++;
            end
            case (wr_mode)
                MODE_COLUMN: begin
                    if (wr_count == WINDOW_BYTES) begin
                        wr_start_x = wr_saved[1];
                        wr_end_x   = wr_saved[3];
                        wr_cur_x   = {1'b0, wr_start_x};
                    end
                end
                MODE_ROW: begin
                    if (wr_count == WINDOW_BYTES) begin
                        wr_start_y = wr_saved[1];
                        wr_end_y   = wr_saved[3];
                        wr_cur_y   = {1'b0, wr_start_y};
                    end
                end
                MODE_PIXEL: begin
                    if (wr_count == PIXEL_BYTES) begin
                        if (wr_cur_y < PANEL_SIZE) begin
                            lo = row_lo[wr_cur_y[7:0]];
                            if (int'(wr_cur_x) >= lo && int'(wr_cur_x) + lo < PANEL_SIZE) begin
                                hit      = 1'b1;
                                px.x     = wr_cur_x[7:0];
                                px.y     = wr_cur_y[7:0];
                                px.value = {wr_saved[1], wr_saved[0]};
                            end
                        end
                        wr_cur_x = cursor_step(wr_cur_x);
                        if (wr_cur_x == {1'b0, wr_end_x}) begin
                            wr_cur_x = {1'b0, wr_start_x};
                            wr_cur_y = cursor_step(wr_cur_y);
                            if (wr_cur_y == {1'b0, wr_end_y}) begin
                                wr_cur_y = {1'b0, wr_start_y};
                            end
                        end
                        wr_count = 0;
                    end
                end
                default: ;
            endcase
        end
    endtask

    function automatic void queue_byte(input logic d, input logic [7:0] b, input bit counts);
        byte_row_t row;
        row         = '0;
        row.is_data = d;
        row.data    = b;
        row.chk     = CHK_PRED;
        byte_q.push_back(row);
        if (counts) begin
            useful++;
        end
    endfunction

    function automatic void load_window(input logic [7:0] cmd, input logic [7:0] s,
                                        input logic [7:0] e);
        queue_byte(1'b0, cmd, 1'b1);
        queue_byte(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        queue_byte(1'b1, s, 1'b1);
        queue_byte(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        queue_byte(1'b1, e, 1'b1);
    endfunction

    function automatic void send_pixels(input int n);
        for (int k = 0; k < 2 * n; k++) begin
            queue_byte(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    function automatic void build_stimulus();
        int         pick;
        int         n;
        bit         wrap_done;
        logic [7:0] cmd;
        logic [7:0] s;
        logic [7:0] e;
        useful    = 0;
        wrap_done = 1'b0;
        foreach (DIR_TAB[i]) begin
            byte_q.push_back(DIR_TAB[i]);
            useful++;
        end
        while (useful < ITEMS) begin
            if (!wrap_done && useful > 700) begin
                // drive the column cursor past the panel until it saturates
                load_window(CMD_ROWS, 8'd100, 8'd110);
                load_window(CMD_COLUMNS, 8'hFF, 8'h00);
                queue_byte(1'b0, CMD_PIXELS, 1'b1);
                send_pixels(260);
                wrap_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                cmd = $urandom_range(0, 1) ? CMD_COLUMNS : CMD_ROWS;
                if ($urandom_range(0, 4) != 0) begin
                    s = 8'($urandom_range(0, 230));
                    e = s + 8'($urandom_range(1, 9));
                end else begin
                    s = 8'($urandom_range(0, 255));
                    e = 8'($urandom_range(0, 255));
                end
                load_window(cmd, s, e);
                n = $urandom_range(0, 19);
                if (n < 2) begin
                    send_pixels(0);
                    for (int k = 0; k < $urandom_range(1, 3); k++) begin
                        queue_byte(1'b1, 8'($urandom_range(0, 255)), 1'b1);
                    end
                end else if (n == 2) begin
                    for (int k = 0; k < $urandom_range(28, 36); k++) begin
                        queue_byte(1'b1, 8'($urandom_range(0, 255)), 1'b1);
                    end
                end
            end else if (pick < 70) begin
                if ($urandom_range(0, 9) < 7) begin
                    queue_byte(1'b0, CMD_PIXELS, 1'b1);
                end
                send_pixels($urandom_range(1, 24));
                if ($urandom_range(0, 9) == 0) begin
                    queue_byte(1'b1, 8'($urandom_range(0, 255)), 1'b1);
                end
            end else if (pick < 85) begin
                cmd = 8'($urandom_range(0, 255));
                queue_byte(1'b0, cmd, 1'b1);
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    queue_byte(1'b1, 8'($urandom_range(0, 255)),
                               cmd == CMD_COLUMNS || cmd == CMD_ROWS || cmd == CMD_PIXELS);
                end
            end else if (pick < 95) begin
                cmd = $urandom_range(0, 1) ? CMD_COLUMNS : CMD_ROWS;
                queue_byte(1'b0, cmd, 1'b1);
                n = $urandom_range(0, 3);
                for (int k = 0; k < n; k++) begin
                    queue_byte(1'b1, 8'($urandom_range(0, 255)), 1'b1);
                end
            end else begin
                send_pixels($urandom_range(1, 12));
            end
        end
    endfunction

    initial begin
        int     r;
        int     d;
        int     n;
        int     s;
        logic   hit;
        t_pixel px;
        r = PANEL_SIZE / 2;
        for (int y = 0; y < 256; y++) begin
            d = (y >= r) ? (y - r) : (r - y);
            n = (d <= r) ? (r * r - d * d) : 0;
            s = r;
            while (s > 0 && (s - 1) * (s - 1) >= n) begin
                s--;
            end
            row_lo[y] = r - s;
        end
        wr_mode    = MODE_PIXEL;
        wr_count   = 0;
        wr_start_x = '0;
        wr_end_x   = '0;
        wr_start_y = '0;
        wr_end_y   = '0;
        wr_cur_x   = '0;
        wr_cur_y   = '0;
        foreach (wr_saved[i]) begin
            wr_saved[i] = '0;
        end
        build_stimulus();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (byte_q[i]) begin
            if (i >= byte_q.size() - TAIL_ITEMS) begin
                quiet = 1'b1;
            end
            if (!quiet && $urandom_range(0, 7) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            push         <= 1'b1;
            i_is_data    <= byte_q[i].is_data;
            i_byte_value <= byte_q[i].data;
            do @(posedge i_clk); while (full);
            predict_pixel(byte_q[i].is_data, byte_q[i].data, hit, px);
            case (byte_q[i].chk)
                CHK_PRED: if (hit) pixel_q.push_back(px);
                CHK_PIX:  pixel_q.push_back(byte_q[i].pix);
                default:  ;
            endcase
            @(negedge i_clk);
        end
        push <= 1'b0;

        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!stall_done && results_seen >= 30) begin
                // hold off long enough for the block to fill and raise full
                stall_done = 1'b1;
                hold_left  = STALL_LEN - 1;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 10) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (pixel_q.size() == 0) begin
                $error("unexpected pixel word: x %0d y %0d value %0h",
                       o_pixel_x, o_pixel_y, o_pixel_value);
                errors++;
            end else begin
                if (o_pixel_x !== pixel_q[0].x) begin
                    $error("pixel_x mismatch: expected %0d, actual %0d", pixel_q[0].x, o_pixel_x);
                    errors++;
                end
                if (o_pixel_y !== pixel_q[0].y) begin
                    $error("pixel_y mismatch: expected %0d, actual %0d", pixel_q[0].y, o_pixel_y);
                    errors++;
                end
                if (o_pixel_value !== pixel_q[0].value) begin
                    $error("pixel_value mismatch: expected %0h, actual %0h",
                           pixel_q[0].value, o_pixel_value);
                    errors++;
                end
                void'(pixel_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WD_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
